// ===== hw/rtl/rtxh_pkg.sv =====
// Shared types and constants of the random-table XOR string hash.
`default_nettype none

package rtxh_pkg;

	// Block sizing
	localparam int MAX_BYTES     = 128;
	localparam int HASH_WIDTH    = 64;
	localparam int WORD_W        = 64;
	localparam int BITS_PER_BYTE = 8;
	localparam int BYTE_W        = 8;
	localparam int IDX_W         = 10;
	localparam int TABLE_DEPTH   = 1 << IDX_W;
	localparam int LANE_W        = $clog2(BITS_PER_BYTE);
	localparam int ROW_W         = IDX_W - LANE_W;
	localparam int ROWS          = TABLE_DEPTH / BITS_PER_BYTE;
	localparam int POS_W         = $clog2(MAX_BYTES + 1);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Hash kept to its low HASH_WIDTH bits
	localparam logic [WORD_W-1:0] HASH_MASK = {WORD_W{1'b1}} >> (WORD_W - HASH_WIDTH);

	// Input opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// One input beat
	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  table_index;
		logic [WORD_W-1:0] table_word;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [WORD_W-1:0] hash_value;
		logic              was_truncated;
	} result_t;

	// Classified command kinds
	typedef enum logic {
		CMD_WRITE,
		CMD_BYTE
	} cmd_kind_t;

	// Command handed from front to back
	typedef struct packed {
		cmd_kind_t                kind;
		logic [ROW_W-1:0]         row;
		logic [LANE_W-1:0]        lane;
		logic [WORD_W-1:0]        word;
		logic [BITS_PER_BYTE-1:0] bit_mask;
		logic                     last;
		logic                     trunc;
	} cmd_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic nonempty;
		logic full;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtxh_front.sv =====
// Front end: accepts beats, tracks string position and classifies each beat.
`default_nettype none

module rtxh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire rtxh_pkg::item_t item,
	input  wire logic          queue_full,
	output logic               push,
	output rtxh_pkg::cmd_t     cmd
);
	import rtxh_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             ended_q, ended_d;
	logic             ovf_q, ovf_d;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	// Classification and next string state
	always_comb begin
		pos_d        = pos_q;
		ended_d      = ended_q;
		ovf_d        = ovf_q;
		cmd.kind     = CMD_WRITE;
		cmd.row      = item.table_index[IDX_W-1:LANE_W];
		cmd.lane     = item.table_index[LANE_W-1:0];
		cmd.word     = item.table_word;
		cmd.bit_mask = '0;
		cmd.last     = 1'b0;
		cmd.trunc    = ovf_q;
		if (item.opcode == OP_BYTE) begin
			cmd.kind = CMD_BYTE;
			cmd.row  = ROW_W'(pos_q);
			cmd.last = item.last_byte;
			if (!ended_q) begin
				if (item.data_byte == '0) begin
					ended_d = 1'b1;
				end else if (pos_q < POS_W'(MAX_BYTES)) begin
					cmd.bit_mask = item.data_byte;
					pos_d        = pos_q + POS_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
			cmd.trunc = ovf_d;
			// end of string: start afresh
			if (item.last_byte) begin
				pos_d   = '0;
				ended_d = 1'b0;
				ovf_d   = 1'b0;
			end
		end
	end

	// String state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ended_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (push) begin
			pos_q   <= pos_d;
			ended_q <= ended_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtxh_queue.sv =====
// Short command queue decoupling the front end from the back end.
`default_nettype none

module rtxh_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rtxh_pkg::cmd_t       push_cmd,
	input  wire logic                 pop,
	output rtxh_pkg::cmd_t            head,
	output rtxh_pkg::queue_status_t   status
);
	import rtxh_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign head            = entry_q[rd_q];
	assign status.nonempty = (count_q != '0);
	assign status.full     = (count_q == QCNT_W'(QUEUE_DEPTH));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtxh_back.sv =====
// Back end: table memory, XOR accumulation and result register.
`default_nettype none

module rtxh_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rtxh_pkg::queue_status_t status,
	input  wire rtxh_pkg::cmd_t          head,
	output logic                         pop,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output rtxh_pkg::result_t            result
);
	import rtxh_pkg::*;

	// One row holds the eight words of one byte position
	logic [BITS_PER_BYTE-1:0][WORD_W-1:0] mem_q [ROWS];

	logic [BITS_PER_BYTE-1:0][WORD_W-1:0] rd_s1;
	cmd_t                                 cmd_s1;
	logic                                 valid_s1;
	logic [WORD_W-1:0]                    run_q;
	logic [WORD_W-1:0]                    sel_xor;
	logic [WORD_W-1:0]                    hash_next;
	logic                                 res_valid_q;
	result_t                              res_q;
	logic                                 advance;

	// Stage 1 moves on unless its result would overwrite a waiting one
	assign advance = valid_s1 && (!cmd_s1.last || !res_valid_q || !result_stall);
	assign pop     = status.nonempty && (!valid_s1 || advance);

	// Table write and row read
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.kind == CMD_WRITE) begin
				mem_q[head.row][head.lane] <= head.word;
			end
			rd_s1  <= mem_q[head.row];
			cmd_s1 <= head;
		end
	end

	// XOR of the words picked by the byte's set bits
	always_comb begin
		sel_xor = '0;
		for (int k = 0; k < BITS_PER_BYTE; k++) begin
			if (cmd_s1.bit_mask[k]) begin
				sel_xor = sel_xor ^ rd_s1[k];
			end
		end
		hash_next = run_q ^ sel_xor;
	end

	// Stage valid, running hash, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			run_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && cmd_s1.kind == CMD_BYTE) begin
				run_q <= cmd_s1.last ? '0 : hash_next;
			end
			if (advance && cmd_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && cmd_s1.last) begin
			res_q.hash_value    <= hash_next & HASH_MASK;
			res_q.was_truncated <= cmd_s1.trunc;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/random_table_xor_string_hash_top.sv =====
// Top level of the random-table XOR string hash.
`default_nettype none

// Takes one beat per cycle, table writes and string bytes alike, as long as the
// result side keeps up; a 4-deep command queue absorbs short result stalls. The
// 1024-word table sits in a 128-row memory, one 512-bit row per byte position,
// so each byte costs one row read and an eight-way XOR in the following cycle.
// A result passes the command queue, the stage-1 register and the result register
// after its last byte is accepted. The table has no reset and no clearing pass:
// entries must be written before a string uses them. After each result the
// string state returns to zero and the table is kept.
module random_table_xor_string_hash_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire rtxh_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output rtxh_pkg::result_t      result
);
	import rtxh_pkg::*;

	cmd_t          push_cmd;
	cmd_t          head;
	logic          push;
	logic          pop;
	queue_status_t status;

	rtxh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (status.full),
		.push       (push),
		.cmd        (push_cmd)
	);

	rtxh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	rtxh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// The back end never takes a command from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.nonempty)
		else $error("pop from empty command queue");

	// An accepted beat is in the queue the cycle after
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> status.nonempty)
		else $error("accepted beat lost from command queue");

	// A full queue always stalls the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> (item_stall && !push))
		else $error("beat pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== tb/random_table_xor_string_hash_top_test.sv =====
// Self-checking testbench of the random-table XOR string hash block.
`timescale 1ns / 1ps

// Tracks the table and string state and holds the hashes still to come out
class xor_hash_board;
	logic [rtxh_pkg::WORD_W-1:0] words [rtxh_pkg::TABLE_DEPTH];
	logic [rtxh_pkg::WORD_W-1:0] acc = '0;
	int                          pos = 0;
	bit                          ended = 1'b0;
	bit                          overflow = 1'b0;
	rtxh_pkg::result_t           pending_hashes [$];
	int                          mismatches = 0;
	int                          reports = 0;
	int                          hashes_seen = 0;
	int                          truncated_seen = 0;
	int                          writes_seen = 0;

	// Fold one accepted input beat into the expected state
	function void absorb_beat(rtxh_pkg::item_t it);
		rtxh_pkg::result_t want;
		if (it.opcode == rtxh_pkg::OP_WRITE) begin
			words[it.table_index] = it.table_word;
			writes_seen++;
			return;
		end
		if (!ended) begin
			if (it.data_byte == '0) begin
				ended = 1'b1;
			end else if (pos < rtxh_pkg::MAX_BYTES) begin
				for (int k = 0; k < rtxh_pkg::BITS_PER_BYTE; k++) begin
					if (it.data_byte[k])
						acc ^= words[pos * rtxh_pkg::BITS_PER_BYTE + k];
				end
				pos++;
			end else begin
				overflow = 1'b1;
			end
		end
		if (it.last_byte) begin
			want.hash_value    = acc & rtxh_pkg::HASH_MASK;
			want.was_truncated = overflow;
			pending_hashes.push_back(want);
			acc      = '0;
			pos      = 0;
			ended    = 1'b0;
			overflow = 1'b0;
		end
	endfunction

	// Compare one result beat with the oldest expected hash
	function void check_hash(rtxh_pkg::result_t got);
		rtxh_pkg::result_t want;
		if (pending_hashes.size() == 0) begin
			mismatches++;
			if (reports < 10)
				$display("hash error: unexpected beat hash=%h trunc=%b",
					got.hash_value, got.was_truncated);
			reports++;
			return;
		end
		want = pending_hashes.pop_front();
		hashes_seen++;
		if (got.was_truncated)
			truncated_seen++;
		if (got.hash_value !== want.hash_value || got.was_truncated !== want.was_truncated) begin
			mismatches++;
			if (reports < 10)
				$display("hash error: want hash=%h trunc=%b, got hash=%h trunc=%b",
					want.hash_value, want.was_truncated, got.hash_value, got.was_truncated);
			reports++;
		end
	endfunction
endclass

module random_table_xor_string_hash_top_test;
	import rtxh_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 560;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	xor_hash_board board;
	int            cycle_count = 0;
	int            beats_sent = 0;
	bit            item_burst = 1'b0;
	bit            result_burst = 1'b0;

	random_table_xor_string_hash_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop on a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("random_table_xor_string_hash_top: mismatch");
		$finish;
	end

	// String byte beat; the write-only fields carry junk
	function automatic item_t byte_beat(logic [BYTE_W-1:0] b, logic last);
		item_t it;
		it.opcode      = OP_BYTE;
		it.table_index = IDX_W'($urandom);
		it.table_word  = {$urandom, $urandom};
		it.data_byte   = b;
		it.last_byte   = last;
		return it;
	endfunction

	// Table write beat; data_byte and last_byte are don't-care here
	function automatic item_t write_beat(int idx, logic [WORD_W-1:0] w, logic last);
		item_t it;
		it.opcode      = OP_WRITE;
		it.table_index = IDX_W'(idx);
		it.table_word  = w;
		it.data_byte   = BYTE_W'($urandom);
		it.last_byte   = last;
		return it;
	endfunction

	// Non-zero byte, biased towards all-ones and single bits
	function automatic logic [BYTE_W-1:0] nonzero_byte();
		case ($urandom_range(0, 7))
			0: return 8'hFF;
			1: return 8'h01 << $urandom_range(0, 7);
			default: return BYTE_W'($urandom_range(1, 255));
		endcase
	endfunction

	// Random word with the occasional all-zero or all-ones value
	function automatic logic [WORD_W-1:0] any_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Drive one input beat after a random gap and wait for it to be taken
	task automatic send_beat(input item_t beat);
		int gap;
		gap = item_burst ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 39) == 0)
			item_burst = !item_burst;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.absorb_beat(beat);
		beats_sent++;
	endtask

	// Result side: random stall before each beat, then take it
	initial begin
		int stall_cycles;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall_cycles = result_burst ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 39) == 0)
				result_burst = !result_burst;
			if (stall_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (stall_cycles) @(negedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			board.check_hash(result);
			@(negedge clk);
		end
	end

	// Main sequence
	initial begin
		int            len;
		int            zero_at;
		int            random_start;
		int            leftover;
		int            failures;
		logic [BYTE_W-1:0] b;
		item_t         junk;

		board      = new();
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole table so no string ever reads an unwritten entry
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(write_beat(i, any_word(), 1'($urandom_range(0, 1))));

		// Directed: extreme words, single bytes, zero bytes, bytes after the end
		send_beat(write_beat(0, '1, 1'b1));
		send_beat(write_beat(7, '0, 1'b0));
		send_beat(write_beat(TABLE_DEPTH - 1, '1, 1'b1));
		send_beat(byte_beat(8'hFF, 1'b1));
		send_beat(byte_beat(8'h01, 1'b0));
		send_beat(byte_beat(8'h80, 1'b1));
		send_beat(byte_beat(8'h00, 1'b1));
		send_beat(byte_beat(8'h55, 1'b0));
		send_beat(byte_beat(8'h00, 1'b0));
		send_beat(byte_beat(8'hAA, 1'b0));
		send_beat(byte_beat(8'h00, 1'b0));
		send_beat(byte_beat(8'h33, 1'b1));
		send_beat(byte_beat(8'hFE, 1'b0));
		send_beat(byte_beat(8'h7F, 1'b0));
		send_beat(byte_beat(8'h80, 1'b1));
		// table write in the middle of a string leaves the string alone
		send_beat(byte_beat(8'h01, 1'b0));
		send_beat(write_beat(0, 64'h1, 1'b1));
		send_beat(byte_beat(8'h02, 1'b1));
		send_beat(byte_beat(8'h00, 1'b0));
		send_beat(byte_beat(8'hFF, 1'b1));

		// Random strings of several shapes, with noise between them
		random_start = beats_sent;
		while (beats_sent < random_start + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					len = $urandom_range(1, 24);
					for (int i = 0; i < len; i++)
						send_beat(byte_beat(nonzero_byte(), i == len - 1));
				end
				6: begin
					// long string near or over the length limit
					len     = $urandom_range(MAX_BYTES - 2, MAX_BYTES + 12);
					zero_at = ($urandom_range(0, 3) == 0) ? MAX_BYTES : -1;
					for (int i = 0; i < len; i++) begin
						b = (i == zero_at) ? 8'h00 : nonzero_byte();
						send_beat(byte_beat(b, i == len - 1));
					end
				end
				7: begin
					// zero byte inside, anything after it
					len     = $urandom_range(2, 24);
					zero_at = $urandom_range(0, len - 1);
					for (int i = 0; i < len; i++) begin
						if (i < zero_at)
							b = nonzero_byte();
						else if (i == zero_at)
							b = 8'h00;
						else
							b = BYTE_W'($urandom);
						send_beat(byte_beat(b, i == len - 1));
					end
				end
				8: begin
					// fully random beats
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						junk.opcode      = 1'($urandom_range(0, 1));
						junk.table_index = IDX_W'($urandom);
						junk.table_word  = any_word();
						junk.data_byte   = BYTE_W'($urandom);
						junk.last_byte   = 1'($urandom_range(0, 1));
						send_beat(junk);
					end
				end
				default: begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++)
						send_beat(write_beat($urandom_range(0, TABLE_DEPTH - 1), any_word(),
							1'($urandom_range(0, 1))));
				end
			endcase
		end
		// close any string left open by the noise
		send_beat(byte_beat(nonzero_byte(), 1'b1));
		@(negedge clk);
		item_valid <= 1'b0;

		// Drain
		while (board.pending_hashes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		leftover = board.pending_hashes.size();
		if (leftover != 0)
			$display("hash error: %0d expected hashes never came out", leftover);
		failures = board.mismatches + leftover;
		$display("run covered %0d beats, %0d table writes, %0d hashes (%0d truncated)",
			beats_sent, board.writes_seen, board.hashes_seen, board.truncated_seen);
		$display("%0d failures over %0d cycles", failures, cycle_count);
		if (failures == 0)
			$display("random_table_xor_string_hash_top: match");
		else
			$display("random_table_xor_string_hash_top: mismatch");
		$finish;
	end

endmodule
